// File: rtl/core/dxt_pkg.sv
// Shared types, format codes and arithmetic helpers for the DXT block decoder.
// No dependencies; compiled first.
package dxt_pkg;

  localparam logic [1:0] FmtDxt1     = 2'd0;
  localparam logic [1:0] FmtExplicit = 2'd1;
  localparam logic [1:0] FmtInterp   = 2'd2;

  localparam int unsigned QueueDepth = 2;

  // One decoded block: per-pixel alpha, colour palette and colour indices
  typedef struct packed {
    logic [15:0][7:0] alpha;
    logic [3:0][7:0]  red;
    logic [3:0][7:0]  green;
    logic [3:0][7:0]  blue;
    logic [15:0][1:0] idx;
  } entry_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x <= 765, by reciprocal 683 / 2^11
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x / 7 for x <= 1785, by reciprocal 2341 / 2^14
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // x / 5 for x <= 1275, by reciprocal 3277 / 2^14
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

endpackage

// File: rtl/core/dxt_blk_if.sv
// Compressed block channel: valid/ready plus the two 64-bit block words.
// No dependencies.
interface dxt_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_word;
  logic [63:0] color_word;

  modport source (output valid, alpha_word, color_word, input ready);
  modport sink   (input valid, alpha_word, color_word, output ready);
endinterface

// File: rtl/core/dxt_pix_if.sv
// Decoded pixel channel: valid/ready plus ARGB, position and last marker.
// No dependencies.
interface dxt_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [3:0] pixel_position;
  logic       last_pixel;

  modport source (output valid, alpha_out, red_out, green_out, blue_out,
                  pixel_position, last_pixel, input ready);
  modport sink   (input valid, alpha_out, red_out, green_out, blue_out,
                  pixel_position, last_pixel, output ready);
endinterface

// File: rtl/core/dxt_front.sv
// Front end: takes a compressed block, builds colour palette and per-pixel alpha.
// Depends on dxt_pkg and dxt_blk_if.
module dxt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      mode_i,
  dxt_blk_if.sink         blk_i,
  output logic            push_o,
  output dxt_pkg::entry_t entry_o,
  input  logic            full_i
);
  import dxt_pkg::*;

  logic        stg_valid_q, stg_valid_d;
  logic [63:0] stg_aw_q, stg_cw_q;
  logic [1:0]  stg_mode_q;
  logic        accept;

  logic [15:0] c0, c1;
  logic        four_col;
  logic [7:0]  r0, r1, g0, g1, b0, b1;
  logic [7:0]  a0, a1;
  logic [7:0][7:0] apal;
  logic [10:0] sum;
  logic [1:0]  ci;
  logic [2:0]  ai;
  logic [3:0]  nib;

  assign accept      = blk_i.valid & blk_i.ready;
  assign push_o      = stg_valid_q;
  assign blk_i.ready = ~stg_valid_q | ~full_i;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (stg_valid_q && !full_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_aw_q   <= blk_i.alpha_word;
      stg_cw_q   <= blk_i.color_word;
      stg_mode_q <= mode_i;
    end
  end

  // Colour palette
  always_comb begin
    c0 = stg_cw_q[15:0];
    c1 = stg_cw_q[31:16];
    four_col = (stg_mode_q == FmtExplicit) || (stg_mode_q == FmtInterp) || (c0 > c1);
    r0 = expand5(c0[15:11]);
    g0 = expand6(c0[10:5]);
    b0 = expand5(c0[4:0]);
    r1 = expand5(c1[15:11]);
    g1 = expand6(c1[10:5]);
    b1 = expand5(c1[4:0]);
    entry_o.red[0]   = r0;
    entry_o.green[0] = g0;
    entry_o.blue[0]  = b0;
    entry_o.red[1]   = r1;
    entry_o.green[1] = g1;
    entry_o.blue[1]  = b1;
    if (four_col) begin
      entry_o.red[2]   = div3({1'b0, r0, 1'b0} + 10'(r1));
      entry_o.green[2] = div3({1'b0, g0, 1'b0} + 10'(g1));
      entry_o.blue[2]  = div3({1'b0, b0, 1'b0} + 10'(b1));
      entry_o.red[3]   = div3(10'(r0) + {1'b0, r1, 1'b0});
      entry_o.green[3] = div3(10'(g0) + {1'b0, g1, 1'b0});
      entry_o.blue[3]  = div3(10'(b0) + {1'b0, b1, 1'b0});
    end else begin
      entry_o.red[2]   = 8'((9'(r0) + 9'(r1)) >> 1);
      entry_o.green[2] = 8'((9'(g0) + 9'(g1)) >> 1);
      entry_o.blue[2]  = 8'((9'(b0) + 9'(b1)) >> 1);
      entry_o.red[3]   = 8'd0;
      entry_o.green[3] = 8'd0;
      entry_o.blue[3]  = 8'd0;
    end
  end

  // Interpolated alpha palette, each entry independent
  always_comb begin
    a0 = stg_aw_q[7:0];
    a1 = stg_aw_q[15:8];
    apal[0] = a0;
    apal[1] = a1;
    for (int k = 1; k < 7; k++) begin
      if (a0 > a1) begin
        sum = 11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1);
        apal[k + 1] = div7(sum);
      end else if (k < 5) begin
        sum = 11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1);
        apal[k + 1] = div5(sum);
      end else begin
        sum = 11'd0;
        apal[k + 1] = (k == 5) ? 8'd0 : 8'd255;
      end
    end
  end

  // Per-pixel alpha and indices
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ci  = stg_cw_q[32 + 2 * i +: 2];
      ai  = stg_aw_q[16 + 3 * i +: 3];
      nib = stg_aw_q[4 * i +: 4];
      entry_o.idx[i] = ci;
      unique case (stg_mode_q)
        FmtExplicit: entry_o.alpha[i] = {nib, nib};
        FmtInterp:   entry_o.alpha[i] = apal[ai];
        default:     entry_o.alpha[i] = (ci == 2'd3 && !four_col) ? 8'd0 : 8'd255;
      endcase
    end
  end

endmodule

// File: rtl/core/dxt_fifo.sv
// Short queue of decoded block entries between front and back end.
// Depends on dxt_pkg.
module dxt_fifo #(
  parameter int unsigned Depth = dxt_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dxt_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output dxt_pkg::entry_t head_o,
  output logic            empty_o
);
  import dxt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/core/dxt_back.sv
// Back end: walks the sixteen pixels of the head entry into the output register.
// Depends on dxt_pkg and dxt_pix_if.
module dxt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dxt_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  dxt_pix_if.source       pix_o
);
  import dxt_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [3:0] pix_q, pix_d;
  logic [7:0] a_q, r_q, g_q, b_q;
  logic [3:0] pos_q;
  logic       last_q;
  logic       load, take;
  logic [1:0] ci;

  assign load  = ~out_valid_q | pix_o.ready;
  assign take  = load & ~empty_i;
  assign pop_o = take & (pix_q == 4'd15);
  assign ci    = head_i.idx[pix_q];

  always_comb begin
    out_valid_d = out_valid_q;
    pix_d       = pix_q;
    if (take) begin
      out_valid_d = 1'b1;
      pix_d       = pix_q + 1'b1;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pix_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pix_q       <= pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_q    <= head_i.alpha[pix_q];
      r_q    <= head_i.red[ci];
      g_q    <= head_i.green[ci];
      b_q    <= head_i.blue[ci];
      pos_q  <= pix_q;
      last_q <= (pix_q == 4'd15);
    end
  end

  assign pix_o.valid          = out_valid_q;
  assign pix_o.alpha_out      = a_q;
  assign pix_o.red_out        = r_q;
  assign pix_o.green_out      = g_q;
  assign pix_o.blue_out       = b_q;
  assign pix_o.pixel_position = pos_q;
  assign pix_o.last_pixel     = last_q;

endmodule

// File: rtl/core/dxt_texture_block_decoder.sv
// DXT1/DXT3/DXT5 4x4 block decoder, sixteen ARGB8888 pixels per block in raster order.
// A block passes the front-end staging register into the queue, its pixels the output register.
// Throughput: one pixel per cycle while the sink is ready and the queue holds a block,
// set by the single output pixel register. The front end decodes the next block meanwhile.
// Reset (asynchronous, active low) empties the pipeline and sets the format to DXT1.
// Depends on dxt_pkg, dxt_blk_if, dxt_pix_if, dxt_front, dxt_fifo, dxt_back.
module dxt_texture_block_decoder #(
  parameter int unsigned QueueDepth = dxt_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  dxt_blk_if.sink    blk_i,
  dxt_pix_if.source  pix_o
);
  import dxt_pkg::*;

  logic [1:0] fmt_q;
  logic       push, full, pop, empty;
  entry_t     entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtDxt1;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  dxt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (fmt_q),
    .blk_i   (blk_i),
    .push_o  (push),
    .entry_o (entry),
    .full_i  (full)
  );

  dxt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  dxt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .pix_o   (pix_o)
  );

endmodule
